/* rtl/core/lbbt_pkg.sv */
// Shared types and constants for the label bounding box tracker.
// Used by every module under rtl/core; depends on nothing.

package lbbt_pkg;

	localparam int KIND_W         = 2;
	localparam int LABEL_W        = 8;
	localparam int DIM_W          = 11;
	localparam int BOX_FIELDS     = 6;
	localparam int CFG_INDEX_W    = 2;
	localparam int LABEL_COUNT_DEF = 256;
	localparam int COORD_BITS_DEF  = 10;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

	// input word kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_VOXEL = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_X = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_Y = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_Z = 2'd2;

	// position counter control
	typedef struct packed {
		logic step;
		logic restart;
	} pos_ctl_t;

	// word leaving the first stage, as seen by the box table
	typedef struct packed {
		logic               fire;
		kind_t              kind;
		logic [LABEL_W-1:0] label;
	} tbl_op_t;

endpackage

/* rtl/core/lbbt_pos.sv */
// Raster position counter (x fastest, then y, then z) for the tracker.
// Depends on lbbt_pkg.

module lbbt_pos #(
	parameter int COORD_BITS = lbbt_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbbt_pkg::pos_ctl_t            ctl,
	input  logic [lbbt_pkg::DIM_W-1:0]    dim_x,
	input  logic [lbbt_pkg::DIM_W-1:0]    dim_y,
	input  logic [lbbt_pkg::DIM_W-1:0]    dim_z,
	output logic [COORD_BITS-1:0]         pos_x,
	output logic [COORD_BITS-1:0]         pos_y,
	output logic [COORD_BITS-1:0]         pos_z
);

	localparam int CW = (COORD_BITS + 1 > lbbt_pkg::DIM_W) ? COORD_BITS + 1 : lbbt_pkg::DIM_W;

	// clamp a dimension to 1 .. 2^COORD_BITS
	function automatic logic [CW-1:0] eff_dim(input logic [lbbt_pkg::DIM_W-1:0] d);
		logic [CW-1:0] de;
		logic [CW-1:0] lim;
		de  = CW'(d);
		lim = CW'(1) << COORD_BITS;
		if (d == '0) begin
			return CW'(1);
		end
		if (de > lim) begin
			return lim;
		end
		return de;
	endfunction

	logic [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [CW-1:0]         inc_x, inc_y, inc_z;
	logic                  room_x, room_y, room_z;

	assign inc_x  = CW'(pos_x_q) + CW'(1);
	assign inc_y  = CW'(pos_y_q) + CW'(1);
	assign inc_z  = CW'(pos_z_q) + CW'(1);
	assign room_x = inc_x < eff_dim(dim_x);
	assign room_y = inc_y < eff_dim(dim_y);
	assign room_z = inc_z < eff_dim(dim_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (ctl.restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (ctl.step) begin
			if (room_x) begin
				pos_x_q <= inc_x[COORD_BITS-1:0];
			end else begin
				pos_x_q <= '0;
				if (room_y) begin
					pos_y_q <= inc_y[COORD_BITS-1:0];
				end else begin
					pos_y_q <= '0;
					pos_z_q <= room_z ? inc_z[COORD_BITS-1:0] : '0;
				end
			end
		end
	end

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_z = pos_z_q;

endmodule

/* rtl/core/lbbt_table.sv */
// Per-label box memory, seen flags and read-modify-write update with forwarding.
// Depends on lbbt_pkg.

module lbbt_table #(
	parameter int LABEL_COUNT = lbbt_pkg::LABEL_COUNT_DEF,
	parameter int COORD_BITS  = lbbt_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    rd_en,
	input  logic [lbbt_pkg::LABEL_W-1:0]            rd_label,
	input  lbbt_pkg::tbl_op_t                       op,
	input  logic [COORD_BITS-1:0]                   pos_x,
	input  logic [COORD_BITS-1:0]                   pos_y,
	input  logic [COORD_BITS-1:0]                   pos_z,
	output logic                                    q_seen,
	output logic [lbbt_pkg::BOX_FIELDS*COORD_BITS-1:0] q_box
);

	localparam int LABEL_SPAN  = 1 << lbbt_pkg::LABEL_W;
	localparam int TABLE_DEPTH = (LABEL_COUNT < LABEL_SPAN) ? LABEL_COUNT : LABEL_SPAN;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CB          = COORD_BITS;
	localparam int BW          = lbbt_pkg::BOX_FIELDS * CB;

	logic [BW-1:0]          mem [TABLE_DEPTH];
	logic [BW-1:0]          rd_box_q;
	logic [TABLE_DEPTH-1:0] seen_q;
	logic                   fwd_en_q;
	logic [IDX_W-1:0]       fwd_idx_q;
	logic [BW-1:0]          fwd_box_q;

	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic             hit;
	logic             wr_en;
	logic [BW-1:0]    cur_box;
	logic [BW-1:0]    new_box;
	logic [CB-1:0]    pos_c [3];

	assign idx      = op.label[IDX_W-1:0];
	assign in_range = 32'(op.label) < 32'(LABEL_COUNT);
	assign hit      = in_range && seen_q[idx];
	assign wr_en    = op.fire && (op.kind == lbbt_pkg::KIND_VOXEL) && in_range;

	// bypass the word written as this one entered the stage
	assign cur_box = (fwd_en_q && (fwd_idx_q == idx)) ? fwd_box_q : rd_box_q;

	assign pos_c[0] = pos_x;
	assign pos_c[1] = pos_y;
	assign pos_c[2] = pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (!seen_q[idx]) begin
				new_box[(2*a)*CB +: CB]   = pos_c[a];
				new_box[(2*a+1)*CB +: CB] = pos_c[a];
			end else begin
				new_box[(2*a)*CB +: CB]   = (pos_c[a] < cur_box[(2*a)*CB +: CB]) ?
					pos_c[a] : cur_box[(2*a)*CB +: CB];
				new_box[(2*a+1)*CB +: CB] = (pos_c[a] > cur_box[(2*a+1)*CB +: CB]) ?
					pos_c[a] : cur_box[(2*a+1)*CB +: CB];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= new_box;
		end
		if (rd_en) begin
			rd_box_q <= mem[rd_label[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (op.fire) begin
			fwd_idx_q <= idx;
			fwd_box_q <= new_box;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			fwd_en_q <= 1'b0;
		end else if (op.fire) begin
			fwd_en_q <= wr_en;
			if (op.kind == lbbt_pkg::KIND_START) begin
				seen_q <= '0;
			end else if (wr_en) begin
				seen_q[idx] <= 1'b1;
			end
		end
	end

	assign q_seen = hit;
	assign q_box  = hit ? cur_box : '0;

endmodule

/* rtl/core/label_bounding_box_tracker.sv */
// Top level of the per-label 3D bounding box tracker.
// Instantiates lbbt_pos and lbbt_table; depends on lbbt_pkg.
// Use:
//   Input words (kind, label) arrive on in_valid / in_stall in raster order,
//   x fastest. A voxel word widens the box of its label at the current
//   position and advances the position; a start word clears every seen
//   flag and returns the position to the origin; a query word produces one
//   output word (seen, min_x .. max_z) on out_valid / out_stall. Voxel,
//   start and unused kinds produce nothing. Labels at or above LABEL_COUNT
//   leave the table alone; a query of one answers unseen with a zero box.
//   Dimensions are written on cfg_we / cfg_index / cfg_data while idle.
// Throughput and result path:
//   One word per cycle while no query waits on a stalled result, set by the
//   read-modify-write of the box memory with a one-entry bypass. A query
//   result passes through the first stage and then the result register.
// Reset and stall:
//   Reset clears the seen flags, the position and the valid flags, and
//   loads 1024 into each dimension. While out_stall holds a pending result,
//   a further query waits in the first stage and in_stall rises; voxel and
//   start words still drain past a stalled result.

module label_bounding_box_tracker #(
	parameter int LABEL_COUNT = lbbt_pkg::LABEL_COUNT_DEF,
	parameter int COORD_BITS  = lbbt_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lbbt_pkg::KIND_W-1:0]         kind,
	input  logic [lbbt_pkg::LABEL_W-1:0]        label,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                seen,
	output logic [COORD_BITS-1:0]               min_x,
	output logic [COORD_BITS-1:0]               max_x,
	output logic [COORD_BITS-1:0]               min_y,
	output logic [COORD_BITS-1:0]               max_y,
	output logic [COORD_BITS-1:0]               min_z,
	output logic [COORD_BITS-1:0]               max_z,
	input  logic                                cfg_we,
	input  logic [lbbt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lbbt_pkg::DIM_W-1:0]          cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int BW = lbbt_pkg::BOX_FIELDS * CB;

	// configuration
	logic [lbbt_pkg::DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;

	// first stage
	logic                         valid_s1;
	lbbt_pkg::kind_t              kind_s1;
	logic [lbbt_pkg::LABEL_W-1:0] label_s1;

	// output register
	logic                  out_valid_q;
	logic                  seen_q;
	logic [BW-1:0]         box_q;

	logic                  accept;
	logic                  blocked;
	logic                  fire;
	lbbt_pkg::pos_ctl_t    pos_ctl;
	lbbt_pkg::tbl_op_t     op;
	logic [CB-1:0]         pos_x, pos_y, pos_z;
	logic                  q_seen;
	logic [BW-1:0]         q_box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= lbbt_pkg::DIM_RESET;
			dim_y_q <= lbbt_pkg::DIM_RESET;
			dim_z_q <= lbbt_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbbt_pkg::REG_DIM_X: dim_x_q <= cfg_data;
				lbbt_pkg::REG_DIM_Y: dim_y_q <= cfg_data;
				lbbt_pkg::REG_DIM_Z: dim_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a query holds in the first stage only while the result register is full and stalled
	assign blocked  = valid_s1 && (kind_s1 == lbbt_pkg::KIND_QUERY) && out_valid_q && out_stall;
	assign fire     = valid_s1 && !blocked;
	assign in_stall = blocked;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= lbbt_pkg::kind_t'(kind);
			label_s1 <= label;
		end
	end

	assign pos_ctl.step    = fire && (kind_s1 == lbbt_pkg::KIND_VOXEL);
	assign pos_ctl.restart = fire && (kind_s1 == lbbt_pkg::KIND_START);

	lbbt_pos #(
		.COORD_BITS(COORD_BITS)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pos_ctl),
		.dim_x  (dim_x_q),
		.dim_y  (dim_y_q),
		.dim_z  (dim_z_q),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z)
	);

	assign op.fire  = fire;
	assign op.kind  = kind_s1;
	assign op.label = label_s1;

	lbbt_table #(
		.LABEL_COUNT(LABEL_COUNT),
		.COORD_BITS (COORD_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_label (label),
		.op       (op),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.q_seen   (q_seen),
		.q_box    (q_box)
	);

	// result register: load on a query leaving the first stage, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (kind_s1 == lbbt_pkg::KIND_QUERY)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (kind_s1 == lbbt_pkg::KIND_QUERY)) begin
			seen_q <= q_seen;
			box_q  <= q_box;
		end
	end

	assign out_valid = out_valid_q;
	assign seen      = seen_q;
	assign min_x     = box_q[0*CB +: CB];
	assign max_x     = box_q[1*CB +: CB];
	assign min_y     = box_q[2*CB +: CB];
	assign max_y     = box_q[3*CB +: CB];
	assign min_z     = box_q[4*CB +: CB];
	assign max_z     = box_q[5*CB +: CB];

endmodule

/* rtl/core/lbbt_checker.sv */
// Port-level checks for label_bounding_box_tracker, and the bind that attaches them.
// Depends on lbbt_pkg.

module lbbt_checker #(
	parameter int COORD_BITS = lbbt_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         seen,
	input logic [COORD_BITS-1:0]        min_x,
	input logic [COORD_BITS-1:0]        max_x,
	input logic [COORD_BITS-1:0]        min_y,
	input logic [COORD_BITS-1:0]        max_y,
	input logic [COORD_BITS-1:0]        min_z,
	input logic [COORD_BITS-1:0]        max_z
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seen) && $stable(min_x) &&
			$stable(max_x) && $stable(min_y) && $stable(max_y) &&
			$stable(min_z) && $stable(max_z))
		else $error("stalled result changed");

	// an unseen label reports an empty box
	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen |-> min_x == '0 && max_x == '0 && min_y == '0 &&
			max_y == '0 && min_z == '0 && max_z == '0)
		else $error("unseen label with non-zero box");

	// a seen label reports an ordered box
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen |-> min_x <= max_x && min_y <= max_y && min_z <= max_z)
		else $error("box minimum above maximum");

	// input backpressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

endmodule

bind label_bounding_box_tracker lbbt_checker #(
	.COORD_BITS(COORD_BITS)
) u_lbbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.seen      (seen),
	.min_x     (min_x),
	.max_x     (max_x),
	.min_y     (min_y),
	.max_y     (max_y),
	.min_z     (min_z),
	.max_z     (max_z)
);

/* tb/label_bounding_box_tracker_test.sv */
// Self-checking testbench for label_bounding_box_tracker: drives voxel, query,
// start and unused words with random idling on both sides and checks every box that
// comes back. Depends on lbbt_pkg and the RTL only.
`timescale 1ns / 1ps

module label_bounding_box_tracker_test;

	localparam int              COORD_W       = lbbt_pkg::COORD_BITS_DEF;
	localparam int              LABELS        = lbbt_pkg::LABEL_COUNT_DEF;
	localparam logic [lbbt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3; // the one kind the block ignores
	localparam int              RANDOM_WORDS  = 1300;
	localparam int              DRAIN_CYCLES  = 6;
	localparam int              CYCLE_LIMIT   = 200000;
	localparam int              MAX_REPORTS   = 10;

	// one label's box as the output port presents it
	typedef struct packed {
		logic               seen;
		logic [COORD_W-1:0] min_x;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] min_y;
		logic [COORD_W-1:0] max_y;
		logic [COORD_W-1:0] min_z;
		logic [COORD_W-1:0] max_z;
	} label_box_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic [lbbt_pkg::KIND_W-1:0]      kind      = '0;
	logic [lbbt_pkg::LABEL_W-1:0]     label     = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             seen;
	logic [COORD_W-1:0]               min_x, max_x, min_y, max_y, min_z, max_z;
	logic                             cfg_we    = 1'b0;
	logic [lbbt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [lbbt_pkg::DIM_W-1:0]       cfg_data  = '0;

	// shadow of the block: dimensions, position and per-label boxes
	logic [lbbt_pkg::DIM_W-1:0] dim_x = lbbt_pkg::DIM_RESET;
	logic [lbbt_pkg::DIM_W-1:0] dim_y = lbbt_pkg::DIM_RESET;
	logic [lbbt_pkg::DIM_W-1:0] dim_z = lbbt_pkg::DIM_RESET;
	logic [COORD_W-1:0]     pos_x = '0;
	logic [COORD_W-1:0]     pos_y = '0;
	logic [COORD_W-1:0]     pos_z = '0;
	label_box_t             label_box [LABELS] = '{default: '0};
	bit                     box_written [LABELS];   // entry loaded at least once since reset

	label_box_t             expected_boxes [$];
	int                     mismatches  = 0;
	int                     cycle_count = 0;
	bit                     steady      = 1'b0;     // suppress idling on both sides

	label_bounding_box_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.label     (label),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.seen      (seen),
		.min_x     (min_x),
		.max_x     (max_x),
		.min_y     (min_y),
		.max_y     (max_y),
		.min_z     (min_z),
		.max_z     (max_z),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abandon the run if the block stops moving.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall the result side now and then, except during a steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 14);
	end

	// ---------------------------------------------------------------- prediction

	// A dimension of zero behaves as one; anything past the coordinate range
	// is clamped to its full size.
	function automatic logic [lbbt_pkg::DIM_W-1:0] effective_dim(
			logic [lbbt_pkg::DIM_W-1:0] d);
		if (d == '0)
			return lbbt_pkg::DIM_W'(1);
		if (d > (1 << COORD_W))
			return lbbt_pkg::DIM_W'(1 << COORD_W);
		return d;
	endfunction

	// Step the raster position: x fastest, then y, then z, wrapping to the
	// origin after the last voxel. A position already past a freshly written
	// dimension wraps as if it had just finished that row, plane or volume.
	task automatic advance_position();
		if ({1'b0, pos_x} + 1 < effective_dim(dim_x)) begin
			pos_x = pos_x + 1'b1;
			return;
		end
		pos_x = '0;
		if ({1'b0, pos_y} + 1 < effective_dim(dim_y)) begin
			pos_y = pos_y + 1'b1;
			return;
		end
		pos_y = '0;
		if ({1'b0, pos_z} + 1 < effective_dim(dim_z)) begin
			pos_z = pos_z + 1'b1;
			return;
		end
		pos_z = '0;
	endtask

	// Apply one accepted word to the shadow state and queue any box it yields.
	task automatic track_word(logic [lbbt_pkg::KIND_W-1:0] k,
			logic [lbbt_pkg::LABEL_W-1:0] lbl);
		label_box_t b;
		case (k)
			lbbt_pkg::KIND_VOXEL: begin
				b = label_box[lbl];
				if (!b.seen) begin
					// first voxel of this label in the volume: box collapses to one point
					b = '{1'b1, pos_x, pos_x, pos_y, pos_y, pos_z, pos_z};
					box_written[lbl] = 1'b1;
				end else begin
					if (pos_x < b.min_x) b.min_x = pos_x;
					if (pos_x > b.max_x) b.max_x = pos_x;
					if (pos_y < b.min_y) b.min_y = pos_y;
					if (pos_y > b.max_y) b.max_y = pos_y;
					if (pos_z < b.min_z) b.min_z = pos_z;
					if (pos_z > b.max_z) b.max_z = pos_z;
				end
				label_box[lbl] = b;
				advance_position();
			end
			lbbt_pkg::KIND_QUERY: begin
				// an unseen label answers with a zero box, whatever the memory holds
				b = label_box[lbl].seen ? label_box[lbl] : '0;
				expected_boxes = {expected_boxes, b};
			end
			lbbt_pkg::KIND_START: begin
				foreach (label_box[i])
					label_box[i].seen = 1'b0;
				pos_x = '0;
				pos_y = '0;
				pos_z = '0;
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------ driving

	// Offer one word, idling first now and then, and hold it until taken.
	// Valid is left high on return so the next word can follow back to back.
	task automatic send_word(logic [lbbt_pkg::KIND_W-1:0] k,
			logic [lbbt_pkg::LABEL_W-1:0] lbl);
		if (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		label    <= lbl;
		do @(posedge clk); while (in_stall);
		track_word(k, lbl);
	endtask

	// Write the selected dimensions once the block has gone quiet: every box
	// back, and a further drain wait for voxel words that are still in flight.
	task automatic write_dims(logic [2:0] sel, logic [lbbt_pkg::DIM_W-1:0] dx,
			logic [lbbt_pkg::DIM_W-1:0] dy, logic [lbbt_pkg::DIM_W-1:0] dz);
		if (sel == '0)
			return;
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sel[0]) begin
			cfg_we <= 1'b1; cfg_index <= lbbt_pkg::REG_DIM_X; cfg_data <= dx;
			@(posedge clk);
			dim_x = dx;
		end
		if (sel[1]) begin
			cfg_we <= 1'b1; cfg_index <= lbbt_pkg::REG_DIM_Y; cfg_data <= dy;
			@(posedge clk);
			dim_y = dy;
		end
		if (sel[2]) begin
			cfg_we <= 1'b1; cfg_index <= lbbt_pkg::REG_DIM_Z; cfg_data <= dz;
			@(posedge clk);
			dim_z = dz;
		end
		cfg_we <= 1'b0;
	endtask

	// ----------------------------------------------------------------- checking

	task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("box mismatch on %s: expected %0d, got %0d (cycle %0d)",
					name, want, got, cycle_count);
		end
	endtask

	// Compare every box taken from the block with the oldest one predicted.
	always @(posedge clk) begin
		label_box_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_boxes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("box word with nothing outstanding (cycle %0d)", cycle_count);
			end else begin
				want = expected_boxes.pop_front();
				check_field("seen",  COORD_W'(want.seen), COORD_W'(seen));
				check_field("min_x", want.min_x, min_x);
				check_field("max_x", want.max_x, max_x);
				check_field("min_y", want.min_y, min_y);
				check_field("max_y", want.max_y, max_y);
				check_field("min_z", want.min_z, min_z);
				check_field("max_z", want.max_z, max_z);
			end
		end
	end

	// -------------------------------------------------------------------- tests

	// Reset dimensions: a short row of voxels, an ignored word, then queries
	// of labels at both ends of the range.
	task automatic test_first_voxels();
		send_word(lbbt_pkg::KIND_VOXEL, 8'h00);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hFF);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h00);
		send_word(KIND_UNUSED, 8'hFF);
		send_word(lbbt_pkg::KIND_QUERY, 8'h00);
		send_word(lbbt_pkg::KIND_QUERY, 8'hFF);
	endtask

	// A start must forget every label and return the position to the origin.
	task automatic test_start_clears();
		send_word(lbbt_pkg::KIND_START, 8'h00);
		send_word(lbbt_pkg::KIND_QUERY, 8'hFF);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hFF);
		send_word(lbbt_pkg::KIND_QUERY, 8'hFF);
	endtask

	// Zero acts as one and oversize values clamp; with x of one, each voxel
	// steps along y.
	task automatic test_dimension_clamp();
		write_dims(3'b111, 11'd0, 11'd2047, 11'd1025);
		send_word(lbbt_pkg::KIND_START, 8'h00);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h0F);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hF0);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h0F);
		send_word(lbbt_pkg::KIND_QUERY, 8'h0F);
	endtask

	// Shrink the volume under a position already beyond it: the row finishes,
	// then y and z both wrap to the origin.
	task automatic test_dims_mid_volume();
		write_dims(3'b111, 11'd2, 11'd1, 11'd1);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hA5);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h5A);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hA5);
		send_word(lbbt_pkg::KIND_QUERY, 8'hA5);
	endtask

	// Run past the end of a two-voxel volume; boxes keep accumulating.
	task automatic test_volume_wrap();
		write_dims(3'b111, 11'd1, 11'd1, 11'd2);
		send_word(lbbt_pkg::KIND_START, 8'h00);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h3C);
		send_word(lbbt_pkg::KIND_VOXEL, 8'hC3);
		send_word(lbbt_pkg::KIND_VOXEL, 8'h3C);
		send_word(lbbt_pkg::KIND_QUERY, 8'h3C);
		send_word(lbbt_pkg::KIND_QUERY, 8'hC3);
	endtask

	function automatic logic [lbbt_pkg::DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 11'd2047;
			2:       return 11'd1024;
			3:       return lbbt_pkg::DIM_W'($urandom_range(1025, 2046));
			4, 5, 6: return lbbt_pkg::DIM_W'($urandom_range(1, 4));
			default: return lbbt_pkg::DIM_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Volumes of random shape. Voxels mostly come from a small set of labels
	// per volume so boxes grow over several rows and planes; queries only ask
	// for labels whose entry has been loaded at some point since reset.
	task automatic test_random_volumes();
		int                           sent = 0;
		int                           phase = 0;
		int                           length;
		int                           r;
		logic [lbbt_pkg::LABEL_W-1:0] palette [4];
		logic [lbbt_pkg::LABEL_W-1:0] lbl;
		logic [lbbt_pkg::KIND_W-1:0]  k;
		while (sent < RANDOM_WORDS) begin
			if (phase == 4) begin
				// deep run along z, one voxel per plane
				write_dims(3'b111, 11'd0, 11'd0, 11'd2047);
				length = 300;
			end else begin
				write_dims(3'($urandom_range(0, 7)), pick_dim(), pick_dim(), pick_dim());
				length = $urandom_range(30, 120);
			end
			steady = (phase == 2);  // one long stretch with no idling anywhere
			foreach (palette[i])
				palette[i] = lbbt_pkg::LABEL_W'($urandom_range(0, LABELS - 1));
			if (phase == 4 || $urandom_range(0, 9) < 7) begin
				send_word(lbbt_pkg::KIND_START,
					lbbt_pkg::LABEL_W'($urandom_range(0, LABELS - 1)));
				sent++;
			end
			repeat (length) begin
				lbl = ($urandom_range(0, 9) < 6) ? palette[$urandom_range(0, 3)]
					: lbbt_pkg::LABEL_W'($urandom_range(0, LABELS - 1));
				r = $urandom_range(0, 99);
				if (r < 70)
					k = lbbt_pkg::KIND_VOXEL;
				else if (r < 90)
					k = box_written[lbl] ? lbbt_pkg::KIND_QUERY : lbbt_pkg::KIND_VOXEL;
				else if (r < 95)
					k = lbbt_pkg::KIND_START;
				else
					k = KIND_UNUSED;
				send_word(k, lbl);
				if (k != KIND_UNUSED)
					sent++;
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_voxels();
		test_start_clears();
		test_dimension_clamp();
		test_dims_mid_volume();
		test_volume_wrap();
		test_random_volumes();

		// drop valid, drain the outstanding boxes and let the pipe settle
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_boxes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
